[design/gble_pkg.sv]
// ----------------------------------------------------------------------------
// gble_pkg
// Types, codes and constants shared by the gap-buffer line editor modules.
// ----------------------------------------------------------------------------
package gble_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam logic [7:0] NEWLINE = 8'h0A;

    // request codes
    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_LEFT   = 3'd1;
    localparam logic [2:0] REQ_RIGHT  = 3'd2;
    localparam logic [2:0] REQ_BKSP   = 3'd3;
    localparam logic [2:0] REQ_UP     = 3'd4;
    localparam logic [2:0] REQ_DOWN   = 3'd5;
    localparam logic [2:0] REQ_READ   = 3'd6;

    // result status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_BOUND = 2'd2;

    // datapath store/count operations
    localparam logic [2:0] OP_NONE    = 3'd0;
    localparam logic [2:0] OP_INSERT  = 3'd1;
    localparam logic [2:0] OP_SHIFT_L = 3'd2;
    localparam logic [2:0] OP_SHIFT_R = 3'd3;
    localparam logic [2:0] OP_DEL     = 3'd4;

    // read address select
    localparam logic [1:0] RS_LEFT = 2'd0;  // last char of left run
    localparam logic [1:0] RS_HEAD = 2'd1;  // first char of right run
    localparam logic [1:0] RS_SCAN = 2'd2;  // char before scan pointer
    localparam logic [1:0] RS_IDX  = 2'd3;  // text index of a read request

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] char_in;
        logic [9:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  line_number;
        logic [9:0]  column;
        logic [10:0] text_length;
        logic [7:0]  read_char;
    } t_out;

    typedef struct packed {
        logic       latch;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic [2:0] op;
        logic       col_dec;
        logic       col_scan;
        logic       line_dec;
        logic       sp_load;
        logic       sp_dec;
        logic       w_load;
        logic       st_load;
        logic [1:0] st;
        logic       rchar_load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       left_zero;
        logic       right_zero;
        logic       full;
        logic       idx_ok;
        logic       rd_nl;
        logic       col_zero;
        logic       col_gt_w;
        logic       col_ge_w;
        logic       sp_zero;
    } t_stat;

endpackage

[design/gble_datapath.sv]
// ----------------------------------------------------------------------------
// gble_datapath
// Text store, gap counters, cursor line/column and scan pointer.
// ----------------------------------------------------------------------------
module gble_datapath #(
    parameter int CAPACITY = gble_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gble_pkg::t_in  i_req,
    input  gble_pkg::t_cmd i_cmd,
    output gble_pkg::t_stat o_stat,
    output gble_pkg::t_out o_res
);
    import gble_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    logic [7:0]    r_mem [CAPACITY];
    logic [7:0]    r_rdata;
    t_in           r_req;
    logic [CW-1:0] r_left, n_left;
    logic [CW-1:0] r_right, n_right;
    logic [CW-1:0] r_line, n_line;
    logic [CW-1:0] r_col, n_col;
    logic [CW-1:0] r_w;
    logic [CW-1:0] r_sp;
    logic [1:0]    r_st;
    logic [7:0]    r_rchar;

    logic [CW-1:0] len;
    logic [CW-1:0] left_m1;
    logic [CW-1:0] head;
    logic [CW-1:0] tail_m1;
    logic [CW-1:0] sp_m1;
    logic [31:0]   idx_addr;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;
    logic          wr_en;
    logic          shift_nl;
    logic          ins_nl;

    assign len     = r_left + r_right;
    assign left_m1 = r_left - CW'(1);
    assign head    = CAP_C - r_right;
    assign tail_m1 = CAP_C - r_right - CW'(1);
    assign sp_m1   = r_sp - CW'(1);
    // left run sits at its text index, right run is offset past the gap
    assign idx_addr = (32'(r_req.read_index) < 32'(r_left)) ? 32'(r_req.read_index)
                    : 32'(r_req.read_index) + 32'(CAP_C - len);
    assign shift_nl = (r_rdata == NEWLINE);
    assign ins_nl   = (r_req.char_in == NEWLINE);

    always_comb begin
        unique case (i_cmd.rd_sel)
            RS_LEFT: rd_addr = left_m1[AW-1:0];
            RS_HEAD: rd_addr = head[AW-1:0];
            RS_SCAN: rd_addr = sp_m1[AW-1:0];
            default: rd_addr = idx_addr[AW-1:0];
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_left[AW-1:0];
        wr_data = r_rdata;
        n_left  = r_left;
        n_right = r_right;
        n_line  = r_line;
        n_col   = r_col;
        case (i_cmd.op)
            OP_INSERT: begin
                wr_en   = 1'b1;
                wr_data = r_req.char_in;
                n_left  = r_left + CW'(1);
                if (ins_nl) begin
                    n_line = r_line + CW'(1);
                    n_col  = '0;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            OP_SHIFT_L: begin
                wr_en   = 1'b1;
                wr_addr = tail_m1[AW-1:0];
                n_left  = left_m1;
                n_right = r_right + CW'(1);
            end
            OP_SHIFT_R: begin
                wr_en   = 1'b1;
                n_left  = r_left + CW'(1);
                n_right = r_right - CW'(1);
                if (shift_nl) begin
                    n_line = r_line + CW'(1);
                    n_col  = '0;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            OP_DEL: n_left = left_m1;
            default: ;
        endcase
        if (i_cmd.line_dec) n_line = r_line - CW'(1);
        if (i_cmd.col_dec)  n_col  = r_col - CW'(1);
        if (i_cmd.col_scan) n_col  = r_left - r_sp;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rdata <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= '0;
            r_right <= '0;
            r_line  <= '0;
            r_col   <= '0;
        end else begin
            r_left  <= n_left;
            r_right <= n_right;
            r_line  <= n_line;
            r_col   <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req   <= i_req;
            r_st    <= ST_DONE;
            r_rchar <= '0;
        end else begin
            if (i_cmd.st_load)    r_st    <= i_cmd.st;
            if (i_cmd.rchar_load) r_rchar <= r_rdata;
        end
        if (i_cmd.w_load) r_w <= r_col;
        // sp_load shares its cycle with a left-run decrement
        if (i_cmd.sp_load)     r_sp <= left_m1;
        else if (i_cmd.sp_dec) r_sp <= sp_m1;
    end

    assign o_stat.req        = r_req.req_type;
    assign o_stat.left_zero  = (r_left == '0);
    assign o_stat.right_zero = (r_right == '0);
    assign o_stat.full       = (len == CAP_C);
    assign o_stat.idx_ok     = (32'(r_req.read_index) < 32'(len));
    assign o_stat.rd_nl      = shift_nl;
    assign o_stat.col_zero   = (r_col == '0);
    assign o_stat.col_gt_w   = (r_col > r_w);
    assign o_stat.col_ge_w   = (r_col >= r_w);
    assign o_stat.sp_zero    = (r_sp == '0);

    assign o_res.status      = r_st;
    assign o_res.line_number = (32'(r_line) > 32'd1023) ? 10'd1023 : 10'(r_line);
    assign o_res.column      = (32'(r_col) > 32'd1023) ? 10'd1023 : 10'(r_col);
    assign o_res.text_length = (32'(len) > 32'd2047) ? 11'd2047 : 11'(len);
    assign o_res.read_char   = r_rchar;

endmodule

[design/gble_ctrl.sv]
// ----------------------------------------------------------------------------
// gble_ctrl
// Request sequencer: gap moves, line scans and result strobe.
// ----------------------------------------------------------------------------
module gble_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  gble_pkg::t_stat i_stat,
    output gble_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);
    import gble_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DECODE   = 5'd1;
    localparam logic [4:0] S_LB_CHK   = 5'd2;
    localparam logic [4:0] S_SC_ISSUE = 5'd3;
    localparam logic [4:0] S_SC_CHK   = 5'd4;
    localparam logic [4:0] S_R_W      = 5'd5;
    localparam logic [4:0] S_UP_A     = 5'd6;
    localparam logic [4:0] S_UP_AW    = 5'd7;
    localparam logic [4:0] S_UP_XW    = 5'd8;
    localparam logic [4:0] S_UP_C     = 5'd9;
    localparam logic [4:0] S_UP_CW    = 5'd10;
    localparam logic [4:0] S_DN_ISSUE = 5'd11;
    localparam logic [4:0] S_DN_W     = 5'd12;
    localparam logic [4:0] S_DN_P1    = 5'd13;
    localparam logic [4:0] S_DN_P1C   = 5'd14;
    localparam logic [4:0] S_RD_W     = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0] r_state, n_state;
    logic       r_up, n_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_up    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_up    <= n_up;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_up    = r_up;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                case (i_stat.req)
                    REQ_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_FULL;
                        end else begin
                            o_cmd.op = OP_INSERT;
                        end
                    end
                    REQ_LEFT, REQ_BKSP: begin
                        if (i_stat.left_zero) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_BOUND;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_LEFT;
                            n_state      = S_LB_CHK;
                        end
                    end
                    REQ_RIGHT: begin
                        if (i_stat.right_zero) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_BOUND;
                        end else begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_HEAD;
                            n_state      = S_R_W;
                        end
                    end
                    REQ_UP: begin
                        if (i_stat.left_zero) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_BOUND;
                        end else begin
                            o_cmd.w_load = 1'b1;
                            n_state      = S_UP_A;
                        end
                    end
                    REQ_DOWN: begin
                        if (i_stat.right_zero) begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_BOUND;
                        end else begin
                            o_cmd.w_load = 1'b1;
                            n_state      = S_DN_ISSUE;
                        end
                    end
                    REQ_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RS_IDX;
                            n_state      = S_RD_W;
                        end else begin
                            o_cmd.st_load = 1'b1;
                            o_cmd.st      = ST_BOUND;
                        end
                    end
                    default: begin
                        o_cmd.st_load = 1'b1;
                        o_cmd.st      = ST_BOUND;
                    end
                endcase
            end
            S_LB_CHK: begin
                o_cmd.op = (i_stat.req == REQ_LEFT) ? OP_SHIFT_L : OP_DEL;
                if (i_stat.rd_nl) begin
                    // crossed a line break: rescan for the column
                    o_cmd.line_dec = 1'b1;
                    o_cmd.sp_load  = 1'b1;
                    n_up           = 1'b0;
                    n_state        = S_SC_ISSUE;
                end else begin
                    o_cmd.col_dec = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_SC_ISSUE: begin
                if (i_stat.sp_zero) begin
                    o_cmd.col_scan = 1'b1;
                    n_state        = r_up ? S_UP_C : S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_SCAN;
                    n_state      = S_SC_CHK;
                end
            end
            S_SC_CHK: begin
                if (i_stat.rd_nl) begin
                    o_cmd.col_scan = 1'b1;
                    n_state        = r_up ? S_UP_C : S_DONE;
                end else begin
                    o_cmd.sp_dec = 1'b1;
                    n_state      = S_SC_ISSUE;
                end
            end
            S_R_W: begin
                o_cmd.op = OP_SHIFT_R;
                n_state  = S_DONE;
            end
            S_UP_A: begin
                // walk back to the line start, then over the line break
                if (!i_stat.col_zero) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_LEFT;
                    n_state      = S_UP_AW;
                end else if (i_stat.left_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_LEFT;
                    n_state      = S_UP_XW;
                end
            end
            S_UP_AW: begin
                o_cmd.op      = OP_SHIFT_L;
                o_cmd.col_dec = 1'b1;
                n_state       = S_UP_A;
            end
            S_UP_XW: begin
                o_cmd.op       = OP_SHIFT_L;
                o_cmd.line_dec = 1'b1;
                o_cmd.sp_load  = 1'b1;
                n_up           = 1'b1;
                n_state        = S_SC_ISSUE;
            end
            S_UP_C: begin
                if (i_stat.col_gt_w) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_LEFT;
                    n_state      = S_UP_CW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_UP_CW: begin
                o_cmd.op      = OP_SHIFT_L;
                o_cmd.col_dec = 1'b1;
                n_state       = S_UP_C;
            end
            S_DN_ISSUE: begin
                if (i_stat.right_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_HEAD;
                    n_state      = S_DN_W;
                end
            end
            S_DN_W: begin
                o_cmd.op = OP_SHIFT_R;
                n_state  = i_stat.rd_nl ? S_DN_P1 : S_DN_ISSUE;
            end
            S_DN_P1: begin
                if (i_stat.col_ge_w || i_stat.right_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RS_HEAD;
                    n_state      = S_DN_P1C;
                end
            end
            S_DN_P1C: begin
                if (i_stat.rd_nl) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = OP_SHIFT_R;
                    n_state  = S_DN_P1;
                end
            end
            S_RD_W: begin
                o_cmd.rchar_load = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

[design/gap_buffer_line_editor.sv]
// ----------------------------------------------------------------------------
// gap_buffer_line_editor
// Fixed-capacity gap-buffer text store with line/column cursor tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request word on i_req while busy is low; the word is
//   taken at that edge and busy stays high until the result is shown.
//   The result word appears on o_res for exactly one cycle with o_valid high;
//   the receiver cannot stall it, so it must take it in that cycle.
// Left/backspace over a line break rescan the line they land on for the
// column; up and down move the gap one character at a time, and up also
// scans the line above. Each gap step is a read then a write of one byte.
// The next request may start the cycle after o_valid. Reset clears the
// cursor, counters and sequencer; the text memory itself is not cleared,
// only written entries are ever read.
// ----------------------------------------------------------------------------
module gap_buffer_line_editor #(
    parameter int CAPACITY = gble_pkg::CAPACITY_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  gble_pkg::t_in  i_req,
    output logic           o_valid,
    output gble_pkg::t_out o_res
);
    import gble_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    gble_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

endmodule

[design/gble_checker.sv]
// ----------------------------------------------------------------------------
// gble_checker
// Port-level checks for the gap-buffer line editor.
// ----------------------------------------------------------------------------
module gble_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_valid,
    input gble_pkg::t_out o_res
);
    import gble_pkg::*;

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_valid_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside a request");

    a_valid_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("busy held after result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_valid))
        else $error("not idle after reset");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_res.status == ST_DONE || o_res.status == ST_FULL ||
                     o_res.status == ST_BOUND))
        else $error("bad status code");

endmodule

bind gap_buffer_line_editor gble_checker u_gble_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_res   (o_res)
);

[tb/tb_gap_buffer_line_editor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gap_buffer_line_editor
// Self-checking bench for the gap-buffer line editor. Requests are driven
// with random pacing, a behavioral copy of the editor predicts each result
// word, and a small scoreboard compares it field by field against o_res.
// ----------------------------------------------------------------------------
module tb_gap_buffer_line_editor;
    import gble_pkg::*;

    localparam int CAP      = CAPACITY_DEF;
    localparam int WD_LIMIT = 40000;

    // ------------------------------------------------------------------
    // scoreboard: holds predicted result words, checks them in order
    // ------------------------------------------------------------------
    class edit_scoreboard;
        t_out pending[$];
        int   errors;
        int   checked;

        function void note_request(t_out exp_word);
            pending.insert(pending.size(), exp_word);
        endfunction

        function void check_result(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("result word with nothing expected: %p", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status);
                errors++;
            end
            if (got.line_number !== e.line_number) begin
                $error("line_number exp %0d got %0d", e.line_number, got.line_number);
                errors++;
            end
            if (got.column !== e.column) begin
                $error("column exp %0d got %0d", e.column, got.column);
                errors++;
            end
            if (got.text_length !== e.text_length) begin
                $error("text_length exp %0d got %0d", e.text_length, got.text_length);
                errors++;
            end
            if (got.read_char !== e.read_char) begin
                $error("read_char exp %0h got %0h", e.read_char, got.read_char);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_in  i_req;
    logic o_valid;
    t_out o_res;

    gap_buffer_line_editor dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    edit_scoreboard sb = new();

    // editor shadow state; text kept as a plain array, cursor separate
    logic [7:0] text_buf [0:CAP-1];
    int         text_len;
    int         cursor;
    int         line_cnt;
    int         col_cnt;

    int  n_accepted;
    int  idle_ok;
    int  wd_count;
    bit  timed_out;
    int  op_hits [0:7];
    int  full_hits;
    int  bound_hits;

    function automatic int find_line_start(int p);
        while (p > 0 && text_buf[p-1] != NEWLINE) p--;
        return p;
    endfunction

    function automatic int find_line_end(int p);
        while (p < text_len && text_buf[p] != NEWLINE) p++;
        return p;
    endfunction

    function automatic int sat10(int v);
        return (v > 1023) ? 1023 : v;
    endfunction

    function automatic t_out predict_edit(t_in rq);
        t_out r;
        int   w, k, s, ps, ln, col;
        logic [7:0] c;
        r = '0;
        r.status = ST_DONE;
        case (rq.req_type)
            REQ_INSERT: begin
                if (text_len >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    for (int i = text_len; i > cursor; i--) text_buf[i] = text_buf[i-1];
                    text_buf[cursor] = rq.char_in;
                    cursor++;
                    text_len++;
                    if (rq.char_in == NEWLINE) begin
                        line_cnt++;
                        col_cnt = 0;
                    end else begin
                        col_cnt++;
                    end
                end
            end
            REQ_LEFT, REQ_BKSP: begin
                if (cursor == 0) begin
                    r.status = ST_BOUND;
                end else begin
                    c = text_buf[cursor-1];
                    if (rq.req_type == REQ_BKSP) begin
                        for (int i = cursor - 1; i < text_len - 1; i++)
                            text_buf[i] = text_buf[i+1];
                        text_len--;
                    end
                    cursor--;
                    if (c == NEWLINE && line_cnt > 0) line_cnt--;
                    col_cnt = cursor - find_line_start(cursor);
                end
            end
            REQ_RIGHT: begin
                if (cursor >= text_len) begin
                    r.status = ST_BOUND;
                end else begin
                    c = text_buf[cursor];
                    cursor++;
                    if (c == NEWLINE) begin
                        line_cnt++;
                        col_cnt = 0;
                    end else begin
                        col_cnt++;
                    end
                end
            end
            REQ_UP: begin
                s = find_line_start(cursor);
                if (s == 0) begin
                    if (cursor == 0) r.status = ST_BOUND;
                    else begin
                        cursor = 0;
                        col_cnt = 0;
                    end
                end else begin
                    w = cursor - s;
                    ps = find_line_start(s - 1);
                    ln = s - 1 - ps;
                    col = (w < ln) ? w : ln;
                    cursor = ps + col;
                    if (line_cnt > 0) line_cnt--;
                    col_cnt = col;
                end
            end
            REQ_DOWN: begin
                if (cursor >= text_len) begin
                    r.status = ST_BOUND;
                end else begin
                    w = cursor - find_line_start(cursor);
                    k = find_line_end(cursor);
                    if (k >= text_len) begin
                        col_cnt = w + (text_len - cursor);
                        cursor = text_len;
                    end else begin
                        ln = find_line_end(k + 1) - (k + 1);
                        col = (w < ln) ? w : ln;
                        cursor = k + 1 + col;
                        line_cnt++;
                        col_cnt = col;
                    end
                end
            end
            REQ_READ: begin
                if (int'(rq.read_index) < text_len) r.read_char = text_buf[rq.read_index];
                else r.status = ST_BOUND;
            end
            default: r.status = ST_BOUND;
        endcase
        r.line_number = sat10(line_cnt);
        r.column      = sat10(col_cnt);
        r.text_length = text_len;
        if (r.status == ST_FULL) full_hits++;
        if (r.status == ST_BOUND) bound_hits++;
        return r;
    endfunction

    // drive one request, return after the accepting edge
    task automatic send_req(input logic [2:0] op, input logic [7:0] ch,
                            input logic [9:0] idx);
        int gap;
        t_in rq;
        rq.req_type = op;
        rq.char_in = ch;
        rq.read_index = idx;
        // the block is busy for at least this edge after an accept
        @(posedge i_clk);
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        // accepted at this edge
        sb.note_request(predict_edit(rq));
        op_hits[op]++;
        n_accepted++;
        start <= 1'b0;
    endtask

    task automatic drain;
        while (sb.pending.size() != 0 && !timed_out) @(posedge i_clk);
    endtask

    // random cursor/read mix with a bias toward typing text
    task automatic random_burst(input int count, input int ins_weight);
        logic [2:0] op;
        logic [7:0] ch;
        int roll;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < ins_weight) op = REQ_INSERT;
            else op = 3'($urandom_range(1, 7));
            if ($urandom_range(0, 5) == 0) ch = NEWLINE;
            else ch = 8'($urandom);
            send_req(op, ch, (text_len > 0 && $urandom_range(0, 3) != 0)
                     ? 10'($urandom_range(0, text_len - 1)) : 10'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) sb.check_result(o_res);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) wd_count <= 0;
        else wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("tb_gap_buffer_line_editor failed");
            $finish;
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        start    = 1'b0;
        i_req    = '0;
        text_len = 0;
        cursor   = 0;
        line_cnt = 0;
        col_cnt  = 0;
        n_accepted = 0;
        idle_ok  = 1;
        wd_count = 0;
        timed_out = 1'b0;
        full_hits = 0;
        bound_hits = 0;
        foreach (op_hits[i]) op_hits[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: boundaries on empty store, then small multi-line text
        send_req(REQ_LEFT,  8'h00, 10'd0);
        send_req(REQ_BKSP,  8'h00, 10'd0);
        send_req(REQ_RIGHT, 8'h00, 10'd0);
        send_req(REQ_UP,    8'h00, 10'd0);
        send_req(REQ_DOWN,  8'h00, 10'd0);
        send_req(REQ_READ,  8'h00, 10'd0);
        send_req(3'd7,      8'hFF, 10'h3FF);
        send_req(REQ_INSERT, 8'hFF, 10'h3FF);
        send_req(REQ_INSERT, 8'h00, 10'd0);
        send_req(REQ_INSERT, NEWLINE, 10'd0);
        send_req(REQ_INSERT, 8'h41, 10'd0);
        send_req(REQ_INSERT, NEWLINE, 10'd0);
        send_req(REQ_INSERT, 8'h55, 10'd0);
        send_req(REQ_INSERT, 8'hAA, 10'd0);
        send_req(REQ_UP,    8'h00, 10'd0);   // clamp to shorter line
        send_req(REQ_UP,    8'h00, 10'd0);
        send_req(REQ_UP,    8'h00, 10'd0);   // first line: to start
        send_req(REQ_UP,    8'h00, 10'd0);   // already at start
        send_req(REQ_DOWN,  8'h00, 10'd0);
        send_req(REQ_DOWN,  8'h00, 10'd0);
        send_req(REQ_DOWN,  8'h00, 10'd0);   // last line: to end
        send_req(REQ_LEFT,  8'h00, 10'd0);
        send_req(REQ_BKSP,  8'h00, 10'd0);   // deletes within the last line
        send_req(REQ_READ,  8'h00, 10'd1);
        send_req(REQ_READ,  8'h00, 10'h3FF); // beyond text

        // pause until the editor has caught up
        drain();

        random_burst(250, 45);
        // fill the store to exercise the full case, with navigation mixed in
        while (text_len < CAP) random_burst(25, 98);
        drain();
        random_burst(60, 60);
        send_req(REQ_READ, 8'h00, 10'h3FF);
        random_burst(150, 40);
        idle_ok = 0;
        random_burst(200, 40);

        drain();
        repeat (50) @(posedge i_clk);
        $display("covered %0d requests: %0d inserts, %0d up, %0d down, %0d reads",
                 n_accepted, op_hits[REQ_INSERT], op_hits[REQ_UP], op_hits[REQ_DOWN],
                 op_hits[REQ_READ]);
        $display("store-full results %0d, boundary results %0d, words checked %0d",
                 full_hits, bound_hits, sb.checked);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_gap_buffer_line_editor passed");
        end else begin
            $display("tb_gap_buffer_line_editor failed");
        end
        $finish;
    end
endmodule
